/* rtl/trv_pkg.sv */
// ----------------------------------------------------------------------------
// Trilinear volume resampler package
// Shared widths, register indexes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package trv_pkg;

  localparam int MAX_DIM     = 64;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int ADDR_W      = 3 * IDX_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CLAMP_EPS   = 66;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIMS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_DIMS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SCALE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK = 3'd7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_BASE,
    ST_ADDR,
    ST_XACC,
    ST_YACC,
    ST_ZACC,
    ST_MAP,
    ST_OUT
  } trv_state_t;

  // Clamp one 7-bit dimension field to lo..MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [6:0] field,
                                                 input logic [DIM_W-1:0] lo);
    logic [DIM_W-1:0] d;
    d = DIM_W'(field);
    if (field < 7'(lo)) d = lo;
    if (field > 7'(MAX_DIM)) d = DIM_W'(MAX_DIM);
    return d;
  endfunction

  // Weight of the lower (d = 0) or upper (d = 1) corner along one axis.
  function automatic logic [16:0] corner_weight(input logic [15:0] w, input logic d);
    return d ? {1'b0, w} : (17'h10000 - {1'b0, w});
  endfunction

endpackage

`default_nettype wire

/* rtl/trv_if.sv */
// ----------------------------------------------------------------------------
// Trilinear volume resampler channels
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface trv_in_if import trv_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic signed [SAMPLE_BITS-1:0] sample_label;
  modport source (output valid, cmd, sample_a, sample_b, sample_label, input ready);
  modport sink   (input valid, cmd, sample_a, sample_b, sample_label, output ready);
endinterface

interface trv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last;
  modport source (output valid, red, green, blue, alpha, last, input ready);
  modport sink   (input valid, red, green, blue, alpha, last, output ready);
endinterface

interface trv_cfg_if import trv_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/trilinear_volume_resampler.sv */
// ----------------------------------------------------------------------------
// Trilinear volume resampler
// Stores up to three scalar volumes and emits resampled RGBA byte voxels.
// ----------------------------------------------------------------------------
// A load item writes one voxel of the volumes A, B and label into the voxel
// store in raster order; load items are taken back to back while the block
// is idle. An emit item produces the next RGBA voxel of the output grid and
// keeps the block busy. It places the sample on each axis and forms the base
// address; then, for each of the eight corners, one state addresses the single
// read port of the voxel store and an x state folds the sample in x through
// the shared multiply-accumulate lane of each channel. The four y folds and
// the two z folds have their own states. A map state turns the values into
// bytes and an output state hands the item to the result register. The memory
// port and the multiplier lanes set the sequence length. A finished item
// waits in the result register while further load items are taken. The voxel
// store holds no reset state: a voxel that was never loaded must not be read.
`default_nettype none

module trilinear_volume_resampler import trv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  trv_in_if.sink    in_ch,
  trv_out_if.source out_ch,
  trv_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [20:0] input_dims_r, output_dims_r;
  logic [23:0] step_x_r, step_y_r, step_z_r, value_scale_r;
  logic [16:0] value_offset_r;
  logic [1:0]  present_mask_r;

  // Sequencer and counters.
  trv_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] load_addr_r;
  logic [IDX_W-1:0]  out_col_r, out_row_r, out_slice_r;
  logic [IDX_W-1:0]  cur_idx_r [3];
  logic              copy_r, last_r;
  logic [1:0]        axis_r;
  logic              phase_r;
  logic [2:0]        corner_r;

  // Sample position per axis.
  logic [IDX_W-1:0]  cell_r [3];
  logic [15:0]       w_r [3];
  logic [11:0]       plane_r;
  logic [12:0]       nxy_r;
  logic [ADDR_W-1:0] base_r;

  // Voxel store, one word holds the three samples of a voxel.
  logic [3*SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [3*SAMPLE_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]        rd_addr;

  // Per-channel accumulators and results.
  logic signed [33:0] accx_r [3];
  logic signed [51:0] accy_r [3];
  logic signed [53:0] accz_r [3];
  logic [7:0]         res_r [3];

  // Result register.
  logic       out_valid_r, out_last_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;

  // Clamped dimensions.
  logic [DIM_W-1:0] ix, iy, iz, ox, oy, oz;
  assign ix = dim_clamp(input_dims_r[6:0], DIM_W'(2));
  assign iy = dim_clamp(input_dims_r[13:7], DIM_W'(2));
  assign iz = dim_clamp(input_dims_r[20:14], DIM_W'(2));
  assign ox = dim_clamp(output_dims_r[6:0], DIM_W'(1));
  assign oy = dim_clamp(output_dims_r[13:7], DIM_W'(1));
  assign oz = dim_clamp(output_dims_r[20:14], DIM_W'(1));

  logic [ADDR_W:0] isize;
  assign isize = (ADDR_W+1)'(ix) * (ADDR_W+1)'(iy) * (ADDR_W+1)'(iz);

  logic in_acc, load_acc, emit_acc, out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign load_acc = in_acc && (in_ch.cmd == CMD_LOAD);
  assign emit_acc = in_acc && (in_ch.cmd == CMD_EMIT);
  assign out_free = !out_valid_r || out_ch.ready;

  // Load address wraps before the write when the input size has shrunk.
  logic [ADDR_W-1:0] load_wr_addr;
  logic [ADDR_W:0]   load_inc;
  assign load_wr_addr = ((ADDR_W+1)'(load_addr_r) >= isize) ? '0 : load_addr_r;
  assign load_inc     = (ADDR_W+1)'(load_wr_addr) + (ADDR_W+1)'(1);

  // Output position of the emit item, restarted at the origin when stale.
  logic             stale;
  logic [IDX_W-1:0] ec, er, es;
  logic [DIM_W-1:0] col_inc, row_inc, slice_inc;
  assign stale = (DIM_W'(out_col_r) >= ox) || (DIM_W'(out_row_r) >= oy) ||
                 (DIM_W'(out_slice_r) >= oz);
  assign ec = stale ? '0 : out_col_r;
  assign er = stale ? '0 : out_row_r;
  assign es = stale ? '0 : out_slice_r;
  assign col_inc   = DIM_W'(ec) + DIM_W'(1);
  assign row_inc   = DIM_W'(er) + DIM_W'(1);
  assign slice_inc = DIM_W'(es) + DIM_W'(1);

  // Axis position: f = index * step, clamped just below dim-1.
  logic [IDX_W-1:0] pos_idx;
  logic [23:0]      pos_step;
  logic [DIM_W-1:0] pos_dim;
  logic [29:0]      pos_f, pos_lim, pos_fc;
  always_comb begin
    case (axis_r)
      2'd0:    begin pos_idx = cur_idx_r[0]; pos_step = step_x_r; pos_dim = ix; end
      2'd1:    begin pos_idx = cur_idx_r[1]; pos_step = step_y_r; pos_dim = iy; end
      default: begin pos_idx = cur_idx_r[2]; pos_step = step_z_r; pos_dim = iz; end
    endcase
    pos_f   = 30'(pos_idx) * 30'(pos_step);
    pos_lim = {8'd0, 6'(pos_dim - DIM_W'(1)), 16'd0};
    pos_fc  = (pos_f >= pos_lim) ? (pos_lim - 30'(CLAMP_EPS)) : pos_f;
  end

  // Corner address and weights of the current corner.
  logic dx, dy, dz, corner_masked;
  assign dx = corner_r[0];
  assign dy = corner_r[1];
  assign dz = corner_r[2];
  assign corner_masked = (dx && w_r[0] == 16'd0) || (dy && w_r[1] == 16'd0) ||
                         (dz && w_r[2] == 16'd0);
  assign rd_addr = ADDR_W'(20'(base_r) + (dz ? 20'(nxy_r) : 20'd0) +
                           (dy ? 20'(ix) : 20'd0) + 20'(dx));

  // Shared multiply lanes, one per channel.
  logic signed [36:0] op_a [3];
  logic [24:0]        op_b;
  logic signed [62:0] prod [3];
  logic signed [39:0] map_s [3];
  logic signed [37:0] map_v [3];
  logic signed [SAMPLE_BITS-1:0] smp [3];

  always_comb begin
    case (state_r)
      ST_XACC: op_b = 25'(corner_weight(w_r[0], dx));
      ST_YACC: op_b = 25'(corner_weight(w_r[1], dy));
      ST_ZACC: op_b = 25'(corner_weight(w_r[2], dz));
      default: op_b = {1'b0, value_scale_r};
    endcase
    for (int l = 0; l < 3; l++) begin
      smp[l]   = corner_masked ? '0 : rd_q[l*SAMPLE_BITS +: SAMPLE_BITS];
      map_v[l] = accz_r[l][53:16];
      map_s[l] = 40'(map_v[l]) + {{7{value_offset_r[16]}}, value_offset_r, 16'd0};
      case (state_r)
        ST_XACC: op_a[l] = 37'(smp[l]);
        ST_YACC: op_a[l] = 37'(accx_r[l]);
        ST_ZACC: op_a[l] = 37'($signed(accy_r[l][51:16]));
        default: op_a[l] = map_s[l][36:0];
      endcase
      prod[l] = 63'(op_a[l]) * 63'($signed({1'b0, op_b}));
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (emit_acc) state_nxt = ST_POS;
      ST_POS:  if (axis_r == 2'd2) state_nxt = ST_BASE;
      ST_BASE: if (phase_r) state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_XACC;
      ST_XACC: state_nxt = dx ? ST_YACC : ST_ADDR;
      ST_YACC: state_nxt = dy ? ST_ZACC : ST_ADDR;
      ST_ZACC: state_nxt = dz ? ST_MAP : ST_ADDR;
      ST_MAP:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    cfg_ch.ready  = 1'b1;
    out_ch.valid  = out_valid_r;
    out_ch.red    = out_red_r;
    out_ch.green  = out_green_r;
    out_ch.blue   = out_blue_r;
    out_ch.alpha  = 8'd0;
    out_ch.last   = out_last_r;
  end

  // Voxel store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      mem[load_wr_addr] <= {in_ch.sample_label, in_ch.sample_b, in_ch.sample_a};
    end
    rd_q <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      input_dims_r   <= 21'd1056832;
      output_dims_r  <= 21'd1056832;
      step_x_r       <= 24'h010000;
      step_y_r       <= 24'h010000;
      step_z_r       <= 24'h010000;
      value_offset_r <= '0;
      value_scale_r  <= 24'h010000;
      present_mask_r <= 2'b11;
      load_addr_r    <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      out_slice_r    <= '0;
      out_valid_r    <= 1'b0;
      axis_r         <= '0;
      phase_r        <= 1'b0;
      corner_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_INPUT_DIMS:   input_dims_r   <= cfg_ch.data[20:0];
          CFG_OUTPUT_DIMS:  output_dims_r  <= cfg_ch.data[20:0];
          CFG_STEP_X:       step_x_r       <= cfg_ch.data;
          CFG_STEP_Y:       step_y_r       <= cfg_ch.data;
          CFG_STEP_Z:       step_z_r       <= cfg_ch.data;
          CFG_VALUE_OFFSET: value_offset_r <= cfg_ch.data[16:0];
          CFG_VALUE_SCALE:  value_scale_r  <= cfg_ch.data;
          CFG_PRESENT_MASK: present_mask_r <= cfg_ch.data[1:0];
          default: ;
        endcase
      end
      if (load_acc) begin
        load_addr_r <= (load_inc >= isize) ? '0 : ADDR_W'(load_inc);
      end
      if (emit_acc) begin
        // Advance the raster position now; the item keeps its own copy.
        axis_r <= '0;
        if (col_inc < ox) begin
          out_col_r   <= IDX_W'(col_inc);
          out_row_r   <= er;
          out_slice_r <= es;
        end else begin
          out_col_r <= '0;
          if (row_inc < oy) begin
            out_row_r   <= IDX_W'(row_inc);
            out_slice_r <= es;
          end else begin
            out_row_r   <= '0;
            out_slice_r <= (slice_inc < oz) ? IDX_W'(slice_inc) : '0;
          end
        end
      end
      if (state_r == ST_POS) begin
        axis_r  <= axis_r + 2'd1;
        phase_r <= 1'b0;
      end
      if (state_r == ST_BASE) begin
        phase_r  <= !phase_r;
        corner_r <= '0;
      end
      if ((state_r == ST_XACC && !dx) || (state_r == ST_YACC && !dy) ||
          (state_r == ST_ZACC && !dz)) begin
        corner_r <= corner_r + 3'd1;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (emit_acc) begin
      cur_idx_r[0] <= ec;
      cur_idx_r[1] <= er;
      cur_idx_r[2] <= es;
      copy_r <= (ix == ox) && (iy == oy) && (iz == oz);
      last_r <= (DIM_W'(ec) == ox - DIM_W'(1)) && (DIM_W'(er) == oy - DIM_W'(1)) &&
                (DIM_W'(es) == oz - DIM_W'(1));
    end
    if (state_r == ST_POS) begin
      // In copy mode the sample sits exactly on the voxel: zero weight.
      cell_r[axis_r] <= copy_r ? pos_idx : pos_fc[16+IDX_W-1:16];
      w_r[axis_r]    <= copy_r ? 16'd0 : pos_fc[15:0];
    end
    if (state_r == ST_BASE) begin
      if (!phase_r) begin
        plane_r <= 12'(13'(cell_r[2]) * 13'(iy) + 13'(cell_r[1]));
        nxy_r   <= 13'(ix) * 13'(iy);
      end else begin
        base_r <= ADDR_W'(19'(plane_r) * 19'(ix) + 19'(cell_r[0]));
      end
    end
    for (int l = 0; l < 3; l++) begin
      case (state_r)
        ST_XACC: accx_r[l] <= dx ? (accx_r[l] + prod[l][33:0]) : prod[l][33:0];
        ST_YACC: accy_r[l] <= dy ? (accy_r[l] + prod[l][51:0]) : prod[l][51:0];
        ST_ZACC: accz_r[l] <= dz ? (accz_r[l] + prod[l][53:0]) : prod[l][53:0];
        ST_MAP: begin
          if (map_s[l] <= 40'sd0 || value_scale_r == 24'd0) begin
            res_r[l] <= 8'd0;
          end else if (prod[l][62:40] != '0) begin
            res_r[l] <= 8'hFF;
          end else begin
            res_r[l] <= prod[l][39:32];
          end
        end
        default: ;
      endcase
    end
    if (state_r == ST_OUT && out_free) begin
      out_red_r   <= res_r[0];
      out_green_r <= present_mask_r[0] ? res_r[1] : 8'd0;
      out_blue_r  <= present_mask_r[1] ? res_r[2] : 8'd0;
      out_last_r  <= last_r;
    end
  end

`ifndef SYNTH
  // The z step is only reached once both y rows of a plane are folded in.
  a_z_after_y: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ZACC) |-> (corner_r[1:0] == 2'b11))
    else $error("z accumulate before a full y pair");

  // Mapping starts only after the last corner.
  a_map_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAP) |-> (corner_r == 3'd7))
    else $error("mapping before all corners were read");

  // An accepted emit item always starts the position sequence.
  a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    emit_acc |=> (state_r == ST_POS && axis_r == 2'd0))
    else $error("emit item did not start the sequencer");

  // Copy mode reads the voxel itself with zero weights on every axis.
  a_copy_weights: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BASE && copy_r) |->
      (w_r[0] == 16'd0 && w_r[1] == 16'd0 && w_r[2] == 16'd0))
    else $error("nonzero weight in copy mode");
`endif

endmodule

`default_nettype wire
